/* src/assert_macros.svh */
// Assertion macros shared by the sorted list RTL.
// No dependencies; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* src/slir_pkg.sv */
// Package for the sorted list insert/remove block: codes, widths, cell structs.
// No dependencies.
package slir_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VAL_W        = 32;
    localparam int CMD_W        = 2;
    localparam int POS_W        = 4;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 5;
    localparam int IN_TDATA_W   = 40;  // 38 bits of fields, padded to whole bytes
    localparam int OUT_TDATA_W  = 72;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_BEYOND    = 2'd3
    } t_status;

    // Broadcast from the control to every cell
    typedef struct packed {
        logic                    ins;
        logic                    rem;
        logic signed [VAL_W-1:0] value;
    } t_cell_ctl;

    // Compare results from one cell
    typedef struct packed {
        logic lt;   // occupied and stored value below the key
        logic hit;  // first occupied cell equal to the key
    } t_cell_stat;

endpackage

/* src/sorted_list_insert_remove.sv */
// Sorted list of signed 32-bit values over a row of compare-and-shift cells.
// Depends on slir_pkg, slir_cell and assert_macros.svh.
//
// Keeps up to CAPACITY values in ascending order. Every cell compares its value
// with the key of the beat in the same cycle and shifts once, so one beat is
// taken per clock and its result appears on the master side in the next cycle
// from an output register; a beat is refused only while that register holds a
// result that has not been taken. The row of cells sets this figure: the
// comparisons run in parallel and the found flag is a reduction over them.
module sorted_list_insert_remove #(
    parameter int CAPACITY = slir_pkg::CAPACITY_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // cmd[1:0], value[33:2], position[37:34], zero pad[39:38]
    input  logic [slir_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // status[1:0], data[33:2], count[38:34], smallest[70:39], nonempty[71]
    output logic [slir_pkg::OUT_TDATA_W-1:0]     o_m_tdata
);
    import slir_pkg::*;
    `include "assert_macros.svh"

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RN = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

    // Input beat fields
    logic [CMD_W-1:0]        w_cmd;
    logic signed [VAL_W-1:0] w_value;
    logic [POS_W-1:0]        w_pos;
    logic                    w_accept;

    assign w_cmd    = i_s_tdata[CMD_W-1:0];
    assign w_value  = i_s_tdata[CMD_W+VAL_W-1:CMD_W];
    assign w_pos    = i_s_tdata[CMD_W+VAL_W+POS_W-1:CMD_W+VAL_W];
    assign w_accept = i_s_tvalid && o_s_tready;

    // Occupancy and output register
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic                    r_out_valid;
    logic [STATUS_W-1:0]     r_status;
    logic signed [VAL_W-1:0] r_data;
    logic [COUNT_W-1:0]      r_count_o;
    logic signed [VAL_W-1:0] r_smallest;
    logic                    r_nonempty;

    // Cell row
    t_cell_ctl               w_ctl;
    t_cell_stat              w_stat [CAPACITY];
    logic [CAPACITY-1:0]     w_hit;
    logic [CAPACITY-1:0]     w_lt;
    logic signed [VAL_W-1:0] w_val  [CAPACITY];
    logic signed [VAL_W-1:0] w_next [CAPACITY];
    logic                    w_full;
    logic                    w_found;

    assign w_full  = (r_count == CW'(CAPACITY));
    assign w_found = |w_hit;

    assign w_ctl.value = w_value;
    assign w_ctl.ins   = w_accept && (w_cmd == CMD_INSERT) && !w_full;
    assign w_ctl.rem   = w_accept && (w_cmd == CMD_REMOVE) && w_found;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                    w_occ;
            logic                    w_left_lt;
            logic signed [VAL_W-1:0] w_left_val;
            logic signed [VAL_W-1:0] w_right_val;

            assign w_occ = (CW'(g) < r_count);

            if (g == 0) begin : g_head
                assign w_left_lt  = 1'b1;
                assign w_left_val = w_value;
            end else begin : g_body
                assign w_left_lt  = w_stat[g-1].lt;
                assign w_left_val = w_val[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_right_val = '0;
            end else begin : g_mid
                assign w_right_val = w_val[g+1];
            end

            slir_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_occ       (w_occ),
                .i_left_lt   (w_left_lt),
                .i_left_val  (w_left_val),
                .i_right_val (w_right_val),
                .o_stat      (w_stat[g]),
                .o_val       (w_val[g]),
                .o_next      (w_next[g])
            );

            assign w_hit[g] = w_stat[g].hit;
            assign w_lt[g]  = w_stat[g].lt;
        end
    endgenerate

    // Read port over the addressable cells
    logic signed [VAL_W-1:0] w_rd_val;
    logic                    w_rd_ok;

    always_comb begin
        w_rd_val = '0;
        for (int k = 0; k < RN; k++) begin
            if (w_pos == POS_W'(k)) begin
                w_rd_val = w_val[k];
            end
        end
    end

    assign w_rd_ok = ({{(32-POS_W){1'b0}}, w_pos} < 32'(r_count)) &&
                     ({{(32-POS_W){1'b0}}, w_pos} < 32'(CAPACITY));

    // Result of the beat
    logic [STATUS_W-1:0]     w_status;
    logic signed [VAL_W-1:0] w_data;

    always_comb begin
        w_status = ST_OK;
        w_data   = '0;
        n_count  = r_count;
        case (w_cmd)
            CMD_INSERT: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            CMD_REMOVE: begin
                if (w_found) begin
                    w_data  = w_value;
                    n_count = r_count - CW'(1);
                end else begin
                    w_status = ST_NOT_FOUND;
                end
            end
            CMD_READ: begin
                if (w_rd_ok) begin
                    w_data = w_rd_val;
                end else begin
                    w_status = ST_BEYOND;
                end
            end
            default: begin
            end
        endcase
    end

    // Occupancy counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status   <= w_status;
            r_data     <= w_data;
            r_count_o  <= COUNT_W'(n_count);
            r_nonempty <= (n_count != '0);
            r_smallest <= (n_count != '0) ? w_next[0] : '0;
        end
    end

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_nonempty, r_smallest, r_count_o, r_data, r_status};

    // Checks
    `ASSERT_ALWAYS(a_count_cap, r_count <= CW'(CAPACITY), "occupancy above capacity")
    `ASSERT_ALWAYS(a_one_hit, $onehot0(w_hit), "more than one first-equal cell")
    `ASSERT_SAME(a_lt_prefix, w_lt[1], w_lt[0], "below-key flags not a prefix")
    `ASSERT_NEXT(a_count_hold, !w_accept, $stable(r_count), "occupancy moved without a beat")

endmodule

/* src/slir_cell.sv */
// One cell of the sorted row: holds a value, compares it with the key and
// shifts left or right under the broadcast control. Depends on slir_pkg.
module slir_cell (
    input  logic                             i_clk,
    input  slir_pkg::t_cell_ctl              i_ctl,
    input  logic                             i_occ,
    input  logic                             i_left_lt,
    input  logic signed [slir_pkg::VAL_W-1:0] i_left_val,
    input  logic signed [slir_pkg::VAL_W-1:0] i_right_val,
    output slir_pkg::t_cell_stat             o_stat,
    output logic signed [slir_pkg::VAL_W-1:0] o_val,
    output logic signed [slir_pkg::VAL_W-1:0] o_next
);
    import slir_pkg::*;

    logic signed [VAL_W-1:0] r_val;
    logic signed [VAL_W-1:0] n_val;
    logic                    w_lt;
    logic                    w_eq;

    // Compare against the key
    assign w_lt = i_occ && (r_val < i_ctl.value);
    assign w_eq = i_occ && (r_val == i_ctl.value);

    assign o_stat.lt  = w_lt;
    assign o_stat.hit = w_eq && i_left_lt;

    // Insert opens a gap at the first cell not below the key;
    // remove closes the gap there by pulling from the right
    always_comb begin
        n_val = r_val;
        if (i_ctl.ins && !w_lt) begin
            n_val = i_left_lt ? i_ctl.value : i_left_val;
        end else if (i_ctl.rem && !w_lt) begin
            n_val = i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val  = r_val;
    assign o_next = n_val;

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for sorted_list_insert_remove: insert, remove and read beats are
// predicted against a shadow copy of the sorted store and checked field by field.
// Depends on slir_pkg and the sorted list RTL.
module tb;
    import slir_pkg::*;

    localparam int CAP        = CAPACITY_DEF;
    localparam int IDLE_LIMIT = 2000;
    localparam logic [CMD_W-1:0]        CMD_UNUSED = 2'd3;
    localparam logic signed [VAL_W-1:0] VAL_MAX    = 32'sh7fff_ffff;
    localparam logic signed [VAL_W-1:0] VAL_MIN    = 32'sh8000_0000;

    // One result beat as the block should report it
    typedef struct {
        t_status                 status;
        logic signed [VAL_W-1:0] data;
        logic [COUNT_W-1:0]      count;
        logic signed [VAL_W-1:0] smallest;
        logic                    nonempty;
    } t_list_result;

    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                   i_m_tready = 1'b0;
    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    // Shadow of the sorted store, updated as each beat is accepted
    logic signed [VAL_W-1:0] shadow_vals [CAP];
    int                      shadow_len  = 0;
    t_list_result            result_due_q [$];

    bit src_stalls    = 1'b1;
    bit sink_stalls   = 1'b1;
    bit fill_trend    = 1'b1;
    int sink_hold_req = 0;
    int mismatch_count = 0;
    int results_seen   = 0;

    sorted_list_insert_remove #(
        .CAPACITY(CAP)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Apply one operation to the shadow store and return the result it should give
    function automatic t_list_result apply_sorted_op(input logic [CMD_W-1:0] cmd,
                                                     input logic signed [VAL_W-1:0] value,
                                                     input logic [POS_W-1:0] pos);
        t_list_result r;
        int at;
        r.status = ST_OK;
        r.data   = '0;
        case (cmd)
            CMD_INSERT: begin
                if (shadow_len >= CAP) begin
                    r.status = ST_FULL;
                end else begin
                    // goes before the first value that is not smaller
                    at = 0;
                    while (at < shadow_len && shadow_vals[at] < value) at++;
                    for (int i = shadow_len; i > at; i--) shadow_vals[i] = shadow_vals[i-1];
                    shadow_vals[at] = value;
                    shadow_len++;
                end
            end
            CMD_REMOVE: begin
                at = 0;
                while (at < shadow_len && shadow_vals[at] != value) at++;
                if (at >= shadow_len) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.data = shadow_vals[at];
                    for (int i = at; i + 1 < shadow_len; i++) shadow_vals[i] = shadow_vals[i+1];
                    shadow_len--;
                end
            end
            CMD_READ: begin
                if (pos < shadow_len) r.data = shadow_vals[pos];
                else r.status = ST_BEYOND;
            end
            default: begin
                // unused code: store untouched, plain ok
            end
        endcase
        r.count    = COUNT_W'(shadow_len);
        r.smallest = (shadow_len > 0) ? shadow_vals[0] : '0;
        r.nonempty = (shadow_len > 0);
        return r;
    endfunction

    // Mostly values that collide, plus full-range and extreme ones
    function automatic logic signed [VAL_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel < 2) return $urandom;
        if (sel < 6) return $urandom_range(0, 15) - 8;
        if (sel == 6) return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
        return $urandom_range(0, 1) ? 0 : -1;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at result %0d: %s got %h, want %h", results_seen, field, got, want);
        mismatch_count++;
    endtask

    // Offer one beat, with an optional gap first; the prediction is taken on acceptance
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic signed [VAL_W-1:0] value,
                             input logic [POS_W-1:0] pos);
        int gap;
        if (src_stalls && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 13);
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_TDATA_W'({pos, value, cmd});
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        result_due_q.push_back(apply_sorted_op(cmd, value, pos));
    endtask

    // Sender goes quiet until every outstanding result is back
    task automatic pause_for_results();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (result_due_q.size() != 0) @(posedge i_clk);
    endtask

    // Random operation; the mix leans towards filling or emptying so both ends are hit
    task automatic send_random_op();
        int roll;
        logic [CMD_W-1:0]        cmd;
        logic signed [VAL_W-1:0] value;
        if (shadow_len == CAP) fill_trend = 1'b0;
        else if (shadow_len == 0) fill_trend = 1'b1;
        roll = $urandom_range(0, 99);
        if (roll < 3) cmd = CMD_UNUSED;
        else if (roll < 23) cmd = CMD_READ;
        else if (($urandom_range(0, 3) != 0) == fill_trend) cmd = CMD_INSERT;
        else cmd = CMD_REMOVE;
        // removes usually name a stored value
        if (cmd == CMD_REMOVE && shadow_len > 0 && $urandom_range(0, 3) != 0)
            value = shadow_vals[$urandom_range(0, shadow_len - 1)];
        else
            value = pick_value();
        send_beat(cmd, value, POS_W'($urandom_range(0, 15)));
    endtask

    // Empty-store cases, extremes, duplicates, reads in and out of range
    task automatic test_directed_ops();
        send_beat(CMD_REMOVE, 5, 0);
        send_beat(CMD_READ, 0, 0);
        send_beat(CMD_INSERT, 0, 0);
        send_beat(CMD_INSERT, VAL_MAX, 0);
        send_beat(CMD_INSERT, VAL_MIN, 0);
        send_beat(CMD_INSERT, -1, 0);
        send_beat(CMD_INSERT, 0, 0);
        send_beat(CMD_INSERT, VAL_MAX, 0);
        send_beat(CMD_READ, 0, 0);
        send_beat(CMD_READ, 0, 5);
        send_beat(CMD_READ, 0, 6);
        send_beat(CMD_REMOVE, 0, 0);
        send_beat(CMD_REMOVE, 7, 0);
        send_beat(CMD_REMOVE, VAL_MIN, 0);
        send_beat(CMD_UNUSED, VAL_MIN, 4'hf);
    endtask

    // Fill to capacity, overflow once, read the last position
    task automatic test_full_store();
        while (shadow_len < CAP) send_beat(CMD_INSERT, 300 - 37 * shadow_len, 0);
        send_beat(CMD_INSERT, VAL_MIN, 0);
        send_beat(CMD_READ, 0, 4'hf);
    endtask

    // Receiver holds off while the sender keeps offering, then the sender drains
    task automatic test_backpressure();
        sink_hold_req = 160;
        repeat (12) send_random_op();
        pause_for_results();
    endtask

    task automatic test_random_traffic();
        for (int i = 0; i < 1300; i++) begin
            if (i % 100 == 0) begin
                src_stalls  = ($urandom_range(0, 3) != 0);
                sink_stalls = ($urandom_range(0, 3) != 0);
            end
            send_random_op();
        end
    endtask

    task automatic test_steady_stream();
        src_stalls  = 1'b0;
        sink_stalls = 1'b0;
        repeat (200) send_random_op();
    endtask

    // Receiver: random stall bursts, or a long hold when one is requested
    initial begin : sink_proc
        int n;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (sink_hold_req != 0) begin
                n = sink_hold_req;
                sink_hold_req = 0;
            end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 13);
            end else begin
                n = 0;
            end
            if (n == 0) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end
        end
    end

    // Compare each result beat against the oldest prediction
    always @(posedge i_clk) begin
        t_list_result due;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (result_due_q.size() == 0) begin
                report_mismatch("result with none expected", 0, 0);
            end else begin
                due = result_due_q.pop_front();
                // status[1:0], data[33:2], count[38:34], smallest[70:39], nonempty[71]
                if (o_m_tdata[1:0] !== due.status)
                    report_mismatch("status", o_m_tdata[1:0], due.status);
                if (o_m_tdata[33:2] !== due.data)
                    report_mismatch("data", o_m_tdata[33:2], due.data);
                if (o_m_tdata[38:34] !== due.count)
                    report_mismatch("count", o_m_tdata[38:34], due.count);
                if (o_m_tdata[70:39] !== due.smallest)
                    report_mismatch("smallest", o_m_tdata[70:39], due.smallest);
                if (o_m_tdata[71] !== due.nonempty)
                    report_mismatch("nonempty", o_m_tdata[71], due.nonempty);
            end
        end
    end

    // Ends the run if no beat moves on either side for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet = 0;
            else quiet++;
        end
        $display("timeout after %0d quiet cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_ops();
        test_full_store();
        test_backpressure();
        test_random_traffic();
        test_steady_stream();
        pause_for_results();
        repeat (4) @(posedge i_clk);
        if (result_due_q.size() != 0)
            report_mismatch("results never arrived", 0, result_due_q.size());
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/slir_pkg.sv
src/slir_cell.sv
src/sorted_list_insert_remove.sv
sim/tb.sv
